// File: design/swm_pkg.sv
// Shared constants and types for the star wildcard matcher.
// Used by swm_cell and star_wildcard_matcher; depends on nothing.
package swm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_NAME    = 1'b1;

    // Signals handed from one position cell to the next.
    typedef struct packed {
        logic init;   // start-of-name closure reaches this position
        logic adv;    // literal match advances into this position
        logic carry;  // star closure ripples into this position
    } swm_link_t;

endpackage

// File: design/swm_cell.sv
// One pattern position: holds a pattern byte and the active bit for it.
// Depends on swm_pkg.
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_byte,
    input  logic       step,
    input  logic       first,
    input  logic [7:0] name_byte,
    input  logic       en,
    input  swm_link_t  link_in,
    output swm_link_t  link_out,
    output logic       act_next
);

    logic [7:0] store_reg;
    logic       act_reg;
    logic       star;
    logic       hit;
    logic       cur;
    logic       hold;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg <= wr_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (step)
        begin
            act_reg <= act_next;
        end
    end

    always_comb
    begin
        star = (store_reg == STAR_BYTE);
        hit  = (store_reg == name_byte);
        // restart from the start-of-name closure on a first byte
        cur  = first ? link_in.init : act_reg;
        hold = cur & en & star;
        act_next = hold | link_in.adv | link_in.carry;
        link_out.init  = link_in.init & en & star;
        link_out.adv   = cur & en & ~star & hit;
        link_out.carry = act_next & en & star;
    end

endmodule

// File: design/star_wildcard_matcher.sv
// Star-only glob matcher: a row of position cells, one request per cycle when not stalled.
// Result: a name byte with last_byte set shows its result in the cycle after acceptance.
// Throughput: one request (pattern or name byte) per cycle while in_stall is low; the star closure ripples
// through the cell row like a carry chain inside that cycle.
// Reset: rst_n clears pattern length, active positions, flags and the output valid;
// the pattern store itself is not cleared. Depends on swm_pkg and swm_cell.
module star_wildcard_matcher
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] byte_value,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    // Control state
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;
    logic             hidden_reg, hidden_next;
    logic             act_end_reg;     // active bit of the position past the last cell

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, matched_next;
    logic             ovf_out_reg, ovf_out_next;

    logic             in_acc;
    logic             pat_acc;
    logic             name_acc;
    logic             store_ok;
    logic [LEN_W-1:0] wr_idx;
    logic             end_hit;

    logic [MAX_PATTERN-1:0] en;
    logic [MAX_PATTERN-1:0] wr_sel;
    logic [MAX_PATTERN:0]   tail;
    logic [MAX_PATTERN:0]   nv;
    swm_link_t              link [0:MAX_PATTERN];

    // Hold the input whenever a result waits and the consumer stalls.
    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;
    assign pat_acc  = in_acc & (opcode == OP_PATTERN);
    assign name_acc = in_acc & (opcode == OP_NAME);

    // A first pattern byte restarts at slot 0; otherwise append if there is room.
    assign store_ok = first_byte | (len_reg < LEN_W'(MAX_PATTERN));
    assign wr_idx   = first_byte ? '0 : len_reg;

    // Per-position enables: live positions, write select, end-of-pattern marker.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            en[i]     = (len_reg > LEN_W'(i));
            wr_sel[i] = pat_acc & store_ok & (wr_idx == LEN_W'(i));
        end
        for (int i = 0; i <= MAX_PATTERN; i++)
        begin
            tail[i] = (len_reg == LEN_W'(i));
        end
    end

    // Cell 0 always starts active on a new name; nothing flows into it.
    assign link[0] = '{init: 1'b1, adv: 1'b0, carry: 1'b0};

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            swm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (wr_sel[g]),
                .wr_byte   (byte_value),
                .step      (name_acc),
                .first     (first_byte),
                .name_byte (byte_value),
                .en        (en[g]),
                .link_in   (link[g]),
                .link_out  (link[g+1]),
                .act_next  (nv[g])
            );
        end
    endgenerate

    // The position past the last cell never holds a byte: it only collects.
    assign nv[MAX_PATTERN] = link[MAX_PATTERN].adv | link[MAX_PATTERN].carry;
    assign end_hit         = |(nv & tail);

    always_comb
    begin
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        hidden_next = hidden_reg;
        if (pat_acc)
        begin
            if (store_ok)
            begin
                len_next = wr_idx + LEN_W'(1);
            end
            // drop the byte and flag overflow when the store is full
            ovf_next = ~first_byte & (ovf_reg | ~store_ok);
        end
        if (name_acc && first_byte)
        begin
            hidden_next = (byte_value == DOT_BYTE);
        end
    end

    // Load a result on the last name byte; advance it out when not stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        matched_next   = matched_reg;
        ovf_out_next   = ovf_out_reg;
        if (name_acc && last_byte)
        begin
            out_valid_next = 1'b1;
            matched_next   = ~ovf_reg & ~hidden_next & end_hit;
            ovf_out_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            hidden_reg    <= 1'b0;
            act_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            hidden_reg    <= hidden_next;
            out_valid_reg <= out_valid_next;
            if (name_acc)
            begin
                act_end_reg <= nv[MAX_PATTERN];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

    // The top position bit is only ever set by a full-length pattern path.
    a_end_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(act_end_reg) |-> (len_reg == LEN_W'(MAX_PATTERN)))
        else $error("end position active without a full pattern");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_W'(MAX_PATTERN)))
        else $error("overflow flag set with room left in store");

    a_no_match_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && ovf_out_reg))
        else $error("match reported together with overflow");

    a_hidden_name: assert property (@(posedge clk) disable iff (!rst_n)
        (name_acc && first_byte && last_byte && byte_value == DOT_BYTE) |=> !matched_reg)
        else $error("hidden name reported as match");

endmodule

// File: tb/swm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the star wildcard matcher: mirrors the position vector per request.
// Watches both channels and compares every result. Depends on swm_pkg.
module swm_checker
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] byte_value,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       matched,
    input  logic       pattern_overflow,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic [7:0]           pat_mem [MAX_PATTERN];
    logic [LEN_W-1:0]     pat_len;
    logic [MAX_PATTERN:0] live_pos;
    logic                 ovf;
    logic                 dot_name;
    verdict_t             verdict_q [$];

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // A star at a live position also makes the next position live.
    function automatic logic [MAX_PATTERN:0] close_stars(input logic [MAX_PATTERN:0] v);
        logic [MAX_PATTERN:0] r;
        int                   i;
        r = v;
        for (i = 0; i < MAX_PATTERN; i++)
            if (i < pat_len && r[i] && pat_mem[i] == STAR_BYTE)
                r[i + 1] = 1'b1;
        return r;
    endfunction

    function automatic logic [MAX_PATTERN:0] advance_on(input logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        int                   i;
        nxt = '0;
        for (i = 0; i < MAX_PATTERN; i++)
            if (i < pat_len && live_pos[i])
            begin
                if (pat_mem[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        return close_stars(nxt);
    endfunction

    task automatic absorb_request();
        verdict_t v;
        if (opcode == OP_PATTERN)
        begin
            if (first_byte)
            begin
                pat_len = '0;
                ovf     = 1'b0;
            end
            if (pat_len < MAX_PATTERN)
            begin
                pat_mem[pat_len[LEN_W-2:0]] = byte_value;
                pat_len++;
            end
            else
                ovf = 1'b1;
        end
        else
        begin
            if (first_byte)
            begin
                live_pos = close_stars({{MAX_PATTERN{1'b0}}, 1'b1});
                dot_name = (byte_value == DOT_BYTE);
            end
            live_pos = advance_on(byte_value);
            if (last_byte)
            begin
                v.matched  = !ovf && !dot_name && live_pos[pat_len];
                v.overflow = ovf;
                verdict_q.push_back(v);
            end
        end
    endtask

    task automatic check_result();
        verdict_t v;
        if (verdict_q.size() == 0)
            report("result with no name waiting");
        else
        begin
            v = verdict_q.pop_front();
            if (matched !== v.matched)
                report($sformatf("matched got %b want %b", matched, v.matched));
            if (pattern_overflow !== v.overflow)
                report($sformatf("pattern_overflow got %b want %b",
                                 pattern_overflow, v.overflow));
        end
    endtask

    // Retire results before absorbing the request of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len    = '0;
            live_pos   = '0;
            ovf        = 1'b0;
            dot_name   = 1'b0;
            verdict_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                absorb_request();
            pending = verdict_q.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the star wildcard matcher testbench: clock, reset, requests and verdict.
// Depends on swm_pkg, star_wildcard_matcher and swm_checker.
module tb_top;
    import swm_pkg::*;

    localparam int TOTAL_REQUESTS = 475;     // directed part plus about 450 random
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;

    // Symbols that names and patterns are built from.
    localparam logic [7:0] SYM_A    = 8'h61;
    localparam logic [7:0] SYM_B    = 8'h62;
    localparam logic [7:0] SYM_C    = 8'h63;
    localparam logic [7:0] SYM_X    = 8'h78;
    localparam logic [7:0] SYM_Z    = 8'h7A;
    localparam logic [7:0] SYM_NUL  = 8'h00;
    localparam logic [7:0] SYM_FULL = 8'hFF;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       opcode = OP_PATTERN;
    logic [7:0] byte_value = 8'h00;
    logic       first_byte = 1'b0;
    logic       last_byte = 1'b0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       matched;
    logic       pattern_overflow;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    int         sent_count = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       req_taken = 1'b0;
    logic [7:0] pat_q [$];

    star_wildcard_matcher uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .byte_value       (byte_value),
        .first_byte       (first_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    swm_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .byte_value       (byte_value),
        .first_byte       (first_byte),
        .last_byte        (last_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always #1 clk = ~clk;

    // Record at each rising edge whether the presented request went in; the
    // stimulus reads this flag at the following falling edge.
    always @(posedge clk)
        req_taken <= in_valid && !in_stall;

    // Stall the result channel at the rate of the current phase.
    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < stall_pct);

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one request at a falling edge and hold it until it is taken.
    // Idle cycles come first, with junk on the payload while valid is low.
    task automatic send_req(input logic op, input logic [7:0] b,
                            input logic first, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid   = 1'b0;
            byte_value = 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        byte_value = b;
        first_byte = first;
        last_byte  = last;
        @(negedge clk);
        while (!req_taken)
            @(negedge clk);
        sent_count++;
    endtask

    // Draw a symbol: mostly a small alphabet so that literals collide often,
    // with star, dot and the byte extremes mixed in.
    function automatic logic [7:0] pick_symbol();
        case ($urandom_range(0, 9))
            0, 1, 2: return SYM_A;
            3, 4:    return SYM_B;
            5:       return SYM_C;
            6:       return STAR_BYTE;
            7:       return DOT_BYTE;
            8:       return ($urandom_range(0, 1) != 0) ? SYM_NUL : SYM_FULL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Load a fresh pattern, or now and then extend the current one. Most are
    // short; a few fill the store exactly and a few run past it.
    task automatic load_pattern();
        int         len;
        int         sel;
        int         i;
        logic       extend;
        logic [7:0] b;
        sel    = $urandom_range(0, 19);
        extend = ($urandom_range(0, 9) == 0);
        if (sel == 0)
            len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
        else if (sel == 1)
            len = MAX_PATTERN;
        else
            len = $urandom_range(1, 8);
        if (!extend)
            pat_q.delete();
        for (i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 9) < 3) ? STAR_BYTE : pick_symbol();
            pat_q.push_back(b);
            // last_byte means nothing on a pattern byte; toggle it anyway
            send_req(OP_PATTERN, b, (i == 0) && !extend, 1'($urandom_range(0, 1)));
        end
    endtask

    // Build a name that fits the current pattern, then maybe break it: mutate
    // a byte, force a leading dot, or drop the start flag.
    task automatic send_name();
        logic [7:0] name_q [$];
        int         i;
        int         run;
        int         pos;
        logic       fresh;
        foreach (pat_q[i])
        begin
            if (pat_q[i] == STAR_BYTE)
            begin
                run = $urandom_range(0, 3);
                repeat (run)
                    name_q.push_back(pick_symbol());
            end
            else
                name_q.push_back(pat_q[i]);
        end
        if (name_q.size() == 0)
            name_q.push_back(pick_symbol());
        if ($urandom_range(0, 9) < 3)
        begin
            pos = $urandom_range(0, name_q.size() - 1);
            name_q[pos] = pick_symbol();
        end
        if ($urandom_range(0, 99) < 8)
            name_q[0] = DOT_BYTE;
        fresh = ($urandom_range(0, 9) != 0);
        for (i = 0; i < name_q.size(); i++)
            send_req(OP_NAME, name_q[i], (i == 0) && fresh, i == name_q.size() - 1);
    endtask

    // Fully random requests, every field drawn over its whole range.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int phase;
        int cur_phase;
        int sel;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, no idling.
        // Name without a start right after reset: the vector is empty.
        send_req(OP_NAME, SYM_X, 1'b0, 1'b1);
        // Pattern "a*<nul>", last_byte set on a pattern byte is ignored.
        send_req(OP_PATTERN, SYM_A, 1'b1, 1'b1);
        send_req(OP_PATTERN, STAR_BYTE, 1'b0, 1'b0);
        send_req(OP_PATTERN, SYM_NUL, 1'b0, 1'b0);
        // "az<nul>" matches, a zero byte is an ordinary literal.
        send_req(OP_NAME, SYM_A, 1'b1, 1'b0);
        send_req(OP_NAME, SYM_Z, 1'b0, 1'b0);
        send_req(OP_NAME, SYM_NUL, 1'b0, 1'b1);
        // A lone zero byte does not.
        send_req(OP_NAME, SYM_NUL, 1'b1, 1'b1);
        // Pattern "*": a dot name is hidden, anything else matches.
        send_req(OP_PATTERN, STAR_BYTE, 1'b1, 1'b0);
        send_req(OP_NAME, DOT_BYTE, 1'b1, 1'b1);
        send_req(OP_NAME, SYM_FULL, 1'b1, 1'b1);
        // Continue the previous name without a start.
        send_req(OP_NAME, SYM_X, 1'b0, 1'b1);
        // Swap the pattern to "ab" in the middle of a name.
        send_req(OP_NAME, SYM_A, 1'b1, 1'b0);
        send_req(OP_PATTERN, SYM_A, 1'b1, 1'b0);
        send_req(OP_PATTERN, SYM_B, 1'b0, 1'b0);
        send_req(OP_NAME, SYM_B, 1'b0, 1'b1);
        // Pattern "<ff>*." with the star taking an empty run.
        send_req(OP_PATTERN, SYM_FULL, 1'b1, 1'b0);
        send_req(OP_PATTERN, STAR_BYTE, 1'b0, 1'b1);
        send_req(OP_PATTERN, DOT_BYTE, 1'b0, 1'b0);
        send_req(OP_NAME, SYM_FULL, 1'b1, 1'b0);
        send_req(OP_NAME, DOT_BYTE, 1'b0, 1'b1);
        // Double star against a name that is itself a star byte.
        send_req(OP_PATTERN, STAR_BYTE, 1'b1, 1'b0);
        send_req(OP_PATTERN, STAR_BYTE, 1'b0, 1'b0);
        send_req(OP_NAME, STAR_BYTE, 1'b1, 1'b1);

        // Random part in four idling phases.
        cur_phase = -1;
        while (sent_count < TOTAL_REQUESTS)
        begin
            phase = (sent_count * 4) / TOTAL_REQUESTS;
            if (phase != cur_phase)
            begin
                cur_phase = phase;
                case (phase)
                    0:       begin idle_pct = 0;  stall_pct = 0;  end
                    1:       begin idle_pct = 72; stall_pct = 0;  end
                    2:       begin idle_pct = 0;  stall_pct = 72; end
                    default: begin idle_pct = 27; stall_pct = 27; end
                endcase
                // Hold off new requests until every result is out, once.
                if (phase == 2)
                begin
                    in_valid = 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            sel = $urandom_range(0, 99);
            if (sel < 20 || pat_q.size() == 0)
                load_pattern();
            else if (sel < 87)
                send_name();
            else
                send_noise();
        end

        // Drain: drop valid, wait for the last result, then run the drain cycles before the verdict.
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: star_wildcard_matcher.f
design/swm_pkg.sv
design/swm_cell.sv
design/star_wildcard_matcher.sv
tb/swm_checker.sv
tb/tb_top.sv
